// File: hw/rtl/ilpc_pkg.sv
// shared types and constants for the ipv4 source lru packet counter
`timescale 1ns / 1ps
`default_nettype none
package ilpc_pkg;

    localparam logic [7:0] ETYPE_HI      = 8'h08;
    localparam logic [7:0] ETYPE_LO      = 8'h00;
    localparam logic [5:0] POS_TYPE_HI   = 6'd12;
    localparam logic [5:0] POS_TYPE_LO   = 6'd13;
    localparam logic [5:0] POS_ADDR_LO   = 6'd26;
    localparam logic [5:0] POS_ADDR_HI   = 6'd29;
    localparam logic [5:0] POS_MIN_LAST  = 6'd33;
    localparam logic [5:0] POS_MAX       = 6'd63;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic        counted;
        logic [31:0] source_address;
        logic [31:0] packet_count;
        logic        new_entry;
    } result_t;

    typedef struct packed {
        logic        counted;
        logic [31:0] addr;
    } job_t;

    typedef struct packed {
        logic ready;
        logic clearing;
    } tbl_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/ilpc_parser.sv
// byte parser: tracks position, ethertype and source address of a frame
`timescale 1ns / 1ps
`default_nettype none
module ilpc_parser (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    input  wire                  item_stall,
    input  ilpc_pkg::item_t      item,
    output logic                 job_valid,
    output ilpc_pkg::job_t       job
);
    import ilpc_pkg::*;

    logic [5:0]  pos_reg,  pos_next;
    logic        type_reg, type_next;
    logic [31:0] addr_reg, addr_next;
    logic        accept;

    assign accept    = item_valid && !item_stall;
    assign job_valid = item_valid && item.frame_end;
    assign job.counted = type_reg && (pos_reg >= POS_MIN_LAST);
    assign job.addr    = addr_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        type_next = type_reg;
        addr_next = addr_reg;
        if (accept)
        begin
            if (pos_reg == POS_TYPE_HI)
                type_next = (item.data_byte == ETYPE_HI);
            else if (pos_reg == POS_TYPE_LO)
                type_next = type_reg && (item.data_byte == ETYPE_LO);
            if (pos_reg >= POS_ADDR_LO && pos_reg <= POS_ADDR_HI)
                addr_next = {addr_reg[23:0], item.data_byte};
            if (pos_reg < POS_MAX)
                pos_next = pos_reg + 6'd1;
            if (item.frame_end)
            begin
                pos_next  = '0;
                type_next = 1'b0;
                addr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            type_reg <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            type_reg <= type_next;
            addr_reg <= addr_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ilpc_table.sv
// lru table engine: scan pass, decision, rank update pass over one memory
`timescale 1ns / 1ps
`default_nettype none
module ilpc_table #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    job_valid,
    input  ilpc_pkg::job_t         job,
    output ilpc_pkg::tbl_status_t  status,
    output logic                   result_valid,
    input  wire                    result_stall,
    output ilpc_pkg::result_t      result
);
    import ilpc_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0]   N_CNT = (AW+1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST  = AW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;

    typedef struct packed {
        logic          valid;
        logic [31:0]   key;
        logic [31:0]   count;
        logic [AW-1:0] rank;
    } entry_t;

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;
    logic [AW-1:0] ra;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   iss_reg, iss_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [31:0]   key_reg, key_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_i_reg, hit_i_next;
    logic [AW-1:0] hit_rank_reg, hit_rank_next;
    logic [31:0]   hit_cnt_reg, hit_cnt_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_i_reg, free_i_next;
    logic          anyv_reg, anyv_next;
    logic [AW-1:0] old_i_reg, old_i_next;
    logic [AW-1:0] old_rank_reg, old_rank_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] lim_reg, lim_next;
    logic          all_reg, all_next;
    logic [31:0]   cnt_reg, cnt_next;
    logic          new_reg, new_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    assign status.ready    = (state_reg == ST_IDLE) && !out_valid_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        hit_i_next     = hit_i_reg;
        hit_rank_next  = hit_rank_reg;
        hit_cnt_next   = hit_cnt_reg;
        free_next      = free_reg;
        free_i_next    = free_i_reg;
        anyv_next      = anyv_reg;
        old_i_next     = old_i_reg;
        old_rank_next  = old_rank_reg;
        slot_next      = slot_reg;
        lim_next       = lim_reg;
        all_next       = all_reg;
        cnt_next       = cnt_reg;
        new_next       = new_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        we             = 1'b0;
        wa             = rd_idx_reg;
        wd             = rdata_reg;
        ra             = iss_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                wa       = iss_reg[AW-1:0];
                wd       = '0;
                iss_next = iss_reg + 1'b1;
                if (iss_reg[AW-1:0] == LAST)
                begin
                    iss_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (job_valid && !out_valid_reg)
                begin
                    if (job.counted)
                    begin
                        key_next   = job.addr;
                        hit_next   = 1'b0;
                        free_next  = 1'b0;
                        anyv_next  = 1'b0;
                        iss_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (iss_reg != N_CNT)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[AW-1:0];
                    iss_next    = iss_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (rdata_reg.valid && rdata_reg.key == key_reg && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_i_next    = rd_idx_reg;
                        hit_rank_next = rdata_reg.rank;
                        hit_cnt_next  = rdata_reg.count;
                    end
                    if (!rdata_reg.valid && !free_reg)
                    begin
                        free_next   = 1'b1;
                        free_i_next = rd_idx_reg;
                    end
                    if (rdata_reg.valid && (!anyv_reg || rdata_reg.rank > old_rank_reg))
                    begin
                        anyv_next     = 1'b1;
                        old_i_next    = rd_idx_reg;
                        old_rank_next = rdata_reg.rank;
                    end
                    if (rd_idx_reg == LAST)
                        state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                iss_next = '0;
                if (hit_reg)
                begin
                    slot_next = hit_i_reg;
                    lim_next  = hit_rank_reg;
                    all_next  = 1'b0;
                    cnt_next  = (&hit_cnt_reg) ? hit_cnt_reg : hit_cnt_reg + 32'd1;
                    new_next  = 1'b0;
                end
                else
                begin
                    // free slot: every valid entry ages; else evict the oldest
                    slot_next = free_reg ? free_i_reg : old_i_reg;
                    lim_next  = old_rank_reg;
                    all_next  = free_reg;
                    cnt_next  = 32'd1;
                    new_next  = 1'b1;
                end
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (iss_reg != N_CNT)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[AW-1:0];
                    iss_next    = iss_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == slot_reg)
                    begin
                        we       = 1'b1;
                        wd.valid = 1'b1;
                        wd.key   = key_reg;
                        wd.count = cnt_reg;
                        wd.rank  = '0;
                    end
                    else if (rdata_reg.valid && (all_reg || rdata_reg.rank < lim_reg))
                    begin
                        we      = 1'b1;
                        wd.rank = rdata_reg.rank + 1'b1;
                    end
                    if (rd_idx_reg == LAST)
                    begin
                        out_valid_next         = 1'b1;
                        out_next.counted        = 1'b1;
                        out_next.source_address = key_reg;
                        out_next.packet_count   = cnt_reg;
                        out_next.new_entry      = new_reg;
                        iss_next                = '0;
                        state_next              = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        key_reg      <= key_next;
        hit_reg      <= hit_next;
        hit_i_reg    <= hit_i_next;
        hit_rank_reg <= hit_rank_next;
        hit_cnt_reg  <= hit_cnt_next;
        free_reg     <= free_next;
        free_i_reg   <= free_i_next;
        anyv_reg     <= anyv_next;
        old_i_reg    <= old_i_next;
        old_rank_reg <= old_rank_next;
        slot_reg     <= slot_next;
        lim_reg      <= lim_next;
        all_reg      <= all_next;
        cnt_reg      <= cnt_next;
        new_reg      <= new_next;
        out_reg      <= out_next;
    end

endmodule
`default_nettype wire

// File: hw/rtl/ipv4_source_lru_packet_counter_unit.sv
// top level of the ipv4 source lru packet counter
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------
//   item     | item_valid / item_stall    | data_byte, frame_end
//   result   | result_valid / result_stall| counted, source_address,
//            |                            | packet_count, new_entry
//
// a byte that is not the last of its frame is taken every cycle, except while the table is clearing
// a counted frame costs in the table engine
// one scan pass and one rank update pass through the single table memory
// the last byte of the next frame stalls until the engine and result register are free
// after reset a clearing pass over every table entry stalls all input
`timescale 1ns / 1ps
`default_nettype none
module ipv4_source_lru_packet_counter_unit #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_stall,
    input  ilpc_pkg::item_t     item,
    output logic                result_valid,
    input  wire                 result_stall,
    output ilpc_pkg::result_t   result
);
    import ilpc_pkg::*;

    logic        job_valid;
    job_t        job;
    tbl_status_t status;

    assign item_stall = status.clearing || (item.frame_end && !status.ready);

    ilpc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .job_valid  (job_valid),
        .job        (job)
    );

    ilpc_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.counted |-> result.packet_count != 32'd0)
        else $error("counted result with zero count");

    a_uncounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.counted |->
            result.packet_count == 32'd0 && result.source_address == 32'd0
            && !result.new_entry)
        else $error("uncounted result carries data");

    a_new_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.new_entry |-> result.packet_count == 32'd1)
        else $error("new entry with count other than one");

endmodule
`default_nettype wire

// File: tb/sv/ipv4_source_lru_packet_counter_unit_checker.sv
// checker: watches both channels, predicts frame results and compares them
`timescale 1ns / 1ps
`default_nettype none
module ipv4_source_lru_packet_counter_unit_checker #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    input  wire                 item_stall,
    input  ilpc_pkg::item_t     item,
    input  wire                 result_valid,
    input  wire                 result_stall,
    input  ilpc_pkg::result_t   result,
    output int                  mismatches,
    output int                  pending
);
    import ilpc_pkg::*;

    logic [5:0]  frame_pos;
    logic        type_ok;
    logic [31:0] src_shift;
    logic [31:0] slot_key [TABLE_ENTRIES];
    logic        slot_used [TABLE_ENTRIES];
    logic [31:0] slot_hits [TABLE_ENTRIES];
    int unsigned slot_rank [TABLE_ENTRIES];
    result_t     frame_results [$];

    assign pending = frame_results.size();

    // move 'slot' to rank 0, pushing back every valid entry ranked below 'limit'
    function automatic void make_newest(int slot, int unsigned limit);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && i != slot && slot_rank[i] < limit)
                slot_rank[i]++;
        slot_rank[slot] = 0;
    endfunction

    function automatic result_t count_source(logic [31:0] addr);
        result_t r;
        int free_slot;
        int oldest;
        int unsigned oldest_rank;
        bit any;
        free_slot = -1;
        oldest = 0;
        oldest_rank = 0;
        any = 0;
        r.counted = 1'b1;
        r.source_address = addr;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == addr) begin
                if (slot_hits[i] != 32'hFFFF_FFFF)
                    slot_hits[i]++;
                make_newest(i, slot_rank[i]);
                r.packet_count = slot_hits[i];
                r.new_entry = 1'b0;
                return r;
            end
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!slot_used[i]) begin
                if (free_slot < 0)
                    free_slot = i;
            end
            else if (!any || slot_rank[i] > oldest_rank) begin
                any = 1;
                oldest = i;
                oldest_rank = slot_rank[i];
            end
        if (free_slot < 0) begin
            slot_used[oldest] = 1'b0;
            free_slot = oldest;
            make_newest(free_slot, oldest_rank);
        end
        else
            make_newest(free_slot, TABLE_ENTRIES);
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot] = addr;
        slot_hits[free_slot] = 32'd1;
        slot_rank[free_slot] = 0;
        r.packet_count = 32'd1;
        r.new_entry = 1'b1;
        return r;
    endfunction

    function automatic void take_byte(item_t it);
        logic [5:0] pos;
        result_t r;
        pos = frame_pos;
        if (pos == POS_TYPE_HI)
            type_ok = (it.data_byte == ETYPE_HI);
        else if (pos == POS_TYPE_LO)
            type_ok = type_ok && (it.data_byte == ETYPE_LO);
        if (pos >= POS_ADDR_LO && pos <= POS_ADDR_HI)
            src_shift = {src_shift[23:0], it.data_byte};
        if (frame_pos < POS_MAX)
            frame_pos++;
        if (it.frame_end) begin
            if (type_ok && pos >= POS_MIN_LAST)
                r = count_source(src_shift);
            else
                r = '0;
            frame_results.push_back(r);
            frame_pos = '0;
            type_ok = 1'b0;
            src_shift = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            frame_pos = '0;
            type_ok = 1'b0;
            src_shift = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
            end
            frame_results.delete();
            mismatches <= 0;
        end
        else begin
            if (item_valid && !item_stall)
                take_byte(item);
            if (result_valid && !result_stall) begin
                if (frame_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transaction: %p", result);
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = frame_results.pop_front();
                    if (want !== result) begin
                        if (mismatches < 10)
                            $display("result mismatch: expected %p actual %p", want, result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/ipv4_source_lru_packet_counter_unit_tb.sv
// testbench top: frame stimulus, random idling and the verdict
`timescale 1ns / 1ps
`default_nettype none
module ipv4_source_lru_packet_counter_unit_tb;
    import ilpc_pkg::*;

    localparam int TABLE_ENTRIES = 128;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    wire     item_stall;
    item_t   item = '0;
    wire     result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    int      mismatches;
    int      pending;
    int      cycles = 0;
    bit      calm = 1'b0;
    logic [31:0] addr_pool [16];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ipv4_source_lru_packet_counter_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    ipv4_source_lru_packet_counter_unit_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .mismatches(mismatches), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
            result_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one byte transaction, with a random idle gap in front
    task automatic send_byte(logic [7:0] b, logic last);
        if (!calm && $urandom_range(99) < 16) begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 30)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{data_byte: b, frame_end: last};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // len bytes; unless noise is set, ethertype and source address laid in when the frame reaches them
    task automatic send_frame(int len, logic [15:0] etype, logic [31:0] src, bit noise);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (!noise) begin
                if (i == 12) b = etype[15:8];
                if (i == 13) b = etype[7:0];
                if (i >= 26 && i <= 29) b = src[8 * (29 - i) +: 8];
            end
            send_byte(b, i == len - 1);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(34, 60);
        if (r < 85) return $urandom_range(61, 90);
        return $urandom_range(1, 33);
    endfunction

    initial
    begin
        logic [31:0] src;
        int r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        send_frame(1, 16'h0800, 32'h0, 0);
        send_frame(33, 16'h0800, 32'h0A000001, 0);
        send_frame(34, 16'h0800, 32'h0A000001, 0);
        send_frame(34, 16'h0800, 32'h0A000001, 0);
        send_frame(34, 16'h0800, 32'h00000000, 0);
        send_frame(34, 16'h0800, 32'hFFFFFFFF, 0);
        send_frame(34, 16'h0801, 32'h0A000001, 0);
        send_frame(34, 16'h0900, 32'h0A000001, 0);
        send_frame(34, 16'hF7FF, 32'h0A000001, 0);
        send_frame(63, 16'h0800, 32'h55AA55AA, 0);
        send_frame(64, 16'h0800, 32'hAA55AA55, 0);
        send_frame(100, 16'h0800, 32'h0A000001, 0);
        send_frame(13, 16'h0800, 32'h0, 0);

        for (int k = 0; k < 16; k++)
            addr_pool[k] = $urandom;
        for (int n = 0; n < 14; n++) begin
            calm = (n >= 4 && n < 9);
            r = $urandom_range(99);
            src = (r < 50) ? addr_pool[$urandom_range(15)]
                : (r < 75) ? (32'hC0A80000 + $urandom_range(200)) : $urandom;
            if (r >= 95)
                send_frame(pick_len(), 16'h0, 32'h0, 1);
            else if (r >= 88)
                send_frame(pick_len(), 16'($urandom), src, 0);
            else
                send_frame(pick_len(), 16'h0800, src, 0);
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (2 * TABLE_ENTRIES + 20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
